[hdl/e2c_pkg.sv]
// Shared types, widths and constants for the epoch seconds to calendar block.
package e2c_pkg;

	// Pipeline depth from input transfer to the output register.
	localparam int STAGES = 9;

	localparam int EPOCH_YEAR_DEF    = 2000;
	localparam int EPOCH_WEEKDAY_DEF = 6;

	localparam int SECS_W     = 32;
	localparam int OFFSET_W   = 17;
	localparam int DAYS_W     = 16;
	localparam int SOD_W      = 17;
	localparam int SOH_W      = 12;
	localparam int YOFF_W     = 8;
	localparam int YEAR_W     = 12;
	localparam int MONTH_W    = 4;
	localparam int DOM_W      = 5;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int SECOND_W   = 6;
	localparam int WEEKDAY_W  = 3;
	localparam int DOY_W      = 9;
	localparam int YSTART_W   = 17;
	localparam int CENT_W     = 5;
	localparam int LCNT_W     = 10;
	localparam int WQ_W       = 14;
	localparam int YEAR_CANDS = 3;

	// Whole days: the seconds are first shifted down by seven, then divided by 675
	// through a reciprocal that is exact for every 25-bit dividend.
	localparam int          DAY_PRE_SHIFT = 7;
	localparam int          DAY_RECIP_W   = 27;
	localparam logic [26:0] DAY_RECIP     = 27'd101806633;
	localparam int          DAY_SHIFT     = 36;
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;

	localparam int          HOUR_RECIP_W  = 21;
	localparam logic [20:0] HOUR_RECIP    = 21'd1193047;
	localparam int          HOUR_SHIFT    = 32;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

	localparam int          MIN_RECIP_W  = 15;
	localparam logic [14:0] MIN_RECIP    = 15'd17477;
	localparam int          MIN_SHIFT    = 20;
	localparam logic [5:0]  SECS_PER_MIN = 6'd60;

	localparam int          WEEK_RECIP_W  = 19;
	localparam logic [18:0] WEEK_RECIP    = 19'd299594;
	localparam int          WEEK_SHIFT    = 21;
	localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

	// Rough year estimate from the mean Gregorian year length; corrected later.
	localparam int          YEAR_RECIP_W = 16;
	localparam logic [15:0] YEAR_RECIP   = 16'd45934;
	localparam int          YEAR_SHIFT   = 24;

	localparam int          C100_RECIP_W      = 13;
	localparam logic [12:0] C100_RECIP        = 13'd5243;
	localparam int          C100_SHIFT        = 19;
	localparam logic [6:0]  YEARS_PER_CENTURY = 7'd100;
	localparam logic [8:0]  DAYS_PER_YEAR     = 9'd365;

	localparam int         MONTHS = 12;
	localparam logic [3:0] MARCH  = 4'd2;
	localparam logic [8:0] MONTH_START [MONTHS] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic [STAGES-1:0] load;
		logic [STAGES-1:0] vld;
	} pipe_ctl_t;

endpackage

[hdl/epoch_seconds_to_calendar.sv]
// Top level: offset register, offset add, day split and the two conversion paths.
//
// Converts a count of seconds since the epoch into Gregorian calendar fields.
// Input channel: in_valid, in_stall, epoch_seconds; a transfer happens when
// in_valid is high and in_stall is low. Output channel: out_valid, out_stall
// and the fields year, month (0 is January), day_of_month, hour, minute,
// second, weekday (0 is Sunday) and day_of_year, one result per input.
// The configuration channel cfg_valid, cfg_ready, utc_offset loads the signed
// offset in seconds that is added before conversion; it is always ready and
// should be written while no item is in flight.
// The block takes one item every cycle while in_stall is low, and the work runs
// through nine register stages, each holding at most one constant multiplier on
// its longest path.
// When the receiver stalls, the result holds on the outputs and the stages
// behind it keep filling; in_stall rises only once all nine stages hold items.
// Reset clears every valid bit and sets the offset to zero.
module epoch_seconds_to_calendar #(
	parameter int EPOCH_YEAR    = e2c_pkg::EPOCH_YEAR_DEF,
	parameter int EPOCH_WEEKDAY = e2c_pkg::EPOCH_WEEKDAY_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic signed [e2c_pkg::OFFSET_W-1:0]    utc_offset,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [e2c_pkg::SECS_W-1:0]             epoch_seconds,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [e2c_pkg::YEAR_W-1:0]             year,
	output logic [e2c_pkg::MONTH_W-1:0]            month,
	output logic [e2c_pkg::DOM_W-1:0]              day_of_month,
	output logic [e2c_pkg::HOUR_W-1:0]             hour,
	output logic [e2c_pkg::MINUTE_W-1:0]           minute,
	output logic [e2c_pkg::SECOND_W-1:0]           second,
	output logic [e2c_pkg::WEEKDAY_W-1:0]          weekday,
	output logic [e2c_pkg::DOY_W-1:0]              day_of_year
);

	localparam int TW  = e2c_pkg::SECS_W;
	localparam int OW  = e2c_pkg::OFFSET_W;
	localparam int XW  = e2c_pkg::SECS_W - e2c_pkg::DAY_PRE_SHIFT;
	localparam int PW  = XW + e2c_pkg::DAY_RECIP_W;
	localparam int DW  = e2c_pkg::DAYS_W;
	localparam int SW  = e2c_pkg::SOD_W;

	e2c_pkg::pipe_ctl_t ctl;

	logic signed [OW-1:0] utc_offset_q;
	logic [TW-1:0]        offset_ext;
	logic [PW-1:0]        day_prod;
	logic [TW-1:0]        t_s1;
	logic [DW-1:0]        days_s2;
	logic [SW-1:0]        sod_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utc_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			utc_offset_q <= utc_offset;
		end
	end

	e2c_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// The sum wraps modulo two to the thirty-second by construction.
	assign offset_ext = {{(TW - OW){utc_offset_q[OW-1]}}, utc_offset_q};

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			t_s1 <= epoch_seconds + offset_ext;
		end
	end

	// Whole days as (t / 128) / 675 through an exact reciprocal.
	assign day_prod = PW'(t_s1[TW-1:e2c_pkg::DAY_PRE_SHIFT]) * PW'(e2c_pkg::DAY_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			days_s2 <= day_prod[e2c_pkg::DAY_SHIFT +: DW];
			sod_s2  <= t_s1[SW-1:0];
		end
	end

	e2c_tod u_tod (
		.clk    (clk),
		.ctl    (ctl),
		.sod_lo (sod_s2),
		.days   (days_s2),
		.hour   (hour),
		.minute (minute),
		.second (second)
	);

	e2c_date #(
		.EPOCH_YEAR    (EPOCH_YEAR),
		.EPOCH_WEEKDAY (EPOCH_WEEKDAY)
	) u_date (
		.clk          (clk),
		.ctl          (ctl),
		.days         (days_s2),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.weekday      (weekday),
		.day_of_year  (day_of_year)
	);

endmodule

[hdl/e2c_pipe_ctl.sv]
// Valid bits and per-stage load enables of the conversion pipeline.
module e2c_pipe_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output e2c_pkg::pipe_ctl_t  ctl
);

	localparam int N = e2c_pkg::STAGES;

	logic [N-1:0] vld_q;
	logic [N-1:0] load;
	logic [N-1:0] vld_next;

	// A stage may load when it is empty or when the stage after it moves on,
	// so bubbles are squeezed out while the receiver stalls.
	always_comb begin
		load[N-1] = !vld_q[N-1] || !out_stall;
		for (int k = N - 2; k >= 0; k--) begin
			load[k] = !vld_q[k] || load[k+1];
		end
	end

	assign vld_next = {vld_q[N-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (load & vld_next) | (~load & vld_q);
		end
	end

	assign in_stall  = !load[0];
	assign out_valid = vld_q[N-1];
	assign ctl.load  = load;
	assign ctl.vld   = vld_q;

`ifndef NO_ASSERTIONS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> ((&vld_q) && out_stall))
		else $error("input stalled while the pipeline had room");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld_q) == $past($countones(vld_q))
			+ int'($past(in_valid && !in_stall)) - int'($past(out_valid && !out_stall))))
		else $error("item count in the pipeline does not match the transfers");

	a_first_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[0] && !load[1]) |=> vld_q[0])
		else $error("first stage dropped an item while blocked");
`endif

endmodule

[hdl/e2c_tod.sv]
// Time-of-day path: second of day, then hour, minute and second.
module e2c_tod (
	input  logic                                 clk,
	input  e2c_pkg::pipe_ctl_t                   ctl,
	input  logic [e2c_pkg::SOD_W-1:0]            sod_lo,
	input  logic [e2c_pkg::DAYS_W-1:0]           days,
	output logic [e2c_pkg::HOUR_W-1:0]           hour,
	output logic [e2c_pkg::MINUTE_W-1:0]         minute,
	output logic [e2c_pkg::SECOND_W-1:0]         second
);

	localparam int SW  = e2c_pkg::SOD_W;
	localparam int HW  = e2c_pkg::SOH_W;
	localparam int DPW = e2c_pkg::DAYS_W + e2c_pkg::SOD_W;
	localparam int HPW = e2c_pkg::SOD_W + e2c_pkg::HOUR_RECIP_W;
	localparam int MPW = e2c_pkg::SOH_W + e2c_pkg::MIN_RECIP_W;
	localparam int HRW = e2c_pkg::HOUR_W;
	localparam int MNW = e2c_pkg::MINUTE_W;
	localparam int SCW = e2c_pkg::SECOND_W;

	logic [DPW-1:0] day_prod;
	logic [HPW-1:0] hour_prod;
	logic [SW-1:0]  hour_secs;
	logic [MPW-1:0] min_prod;
	logic [HW-1:0]  min_secs;

	logic [SW-1:0]  sod_s3, sod_s4;
	logic [HRW-1:0] hour_s4, hour_s5, hour_s6, hour_s7, hour_s8, hour_s9;
	logic [HW-1:0]  soh_s5, soh_s6;
	logic [MNW-1:0] minute_s6, minute_s7, minute_s8, minute_s9;
	logic [SCW-1:0] second_s7, second_s8, second_s9;

	// Only the low bits matter: the true remainder is below one day.
	assign day_prod  = DPW'(days) * DPW'(e2c_pkg::SECS_PER_DAY);
	assign hour_prod = HPW'(sod_s3) * HPW'(e2c_pkg::HOUR_RECIP);
	assign hour_secs = SW'(hour_s4) * SW'(e2c_pkg::SECS_PER_HOUR);
	assign min_prod  = MPW'(soh_s5) * MPW'(e2c_pkg::MIN_RECIP);
	assign min_secs  = HW'(minute_s6) * HW'(e2c_pkg::SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			sod_s3 <= sod_lo - day_prod[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			hour_s4 <= hour_prod[e2c_pkg::HOUR_SHIFT +: HRW];
			sod_s4  <= sod_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			soh_s5  <= HW'(sod_s4 - hour_secs);
			hour_s5 <= hour_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			minute_s6 <= min_prod[e2c_pkg::MIN_SHIFT +: MNW];
			soh_s6    <= soh_s5;
			hour_s6   <= hour_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			second_s7 <= SCW'(soh_s6 - min_secs);
			minute_s7 <= minute_s6;
			hour_s7   <= hour_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			second_s8 <= second_s7;
			minute_s8 <= minute_s7;
			hour_s8   <= hour_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[8]) begin
			second_s9 <= second_s8;
			minute_s9 <= minute_s8;
			hour_s9   <= hour_s8;
		end
	end

	assign hour   = hour_s9;
	assign minute = minute_s9;
	assign second = second_s9;

endmodule

[hdl/e2c_date.sv]
// Date path: weekday, year with leap correction, day of year, month and day.
module e2c_date #(
	parameter int EPOCH_YEAR    = e2c_pkg::EPOCH_YEAR_DEF,
	parameter int EPOCH_WEEKDAY = e2c_pkg::EPOCH_WEEKDAY_DEF
) (
	input  logic                                 clk,
	input  e2c_pkg::pipe_ctl_t                   ctl,
	input  logic [e2c_pkg::DAYS_W-1:0]           days,
	output logic [e2c_pkg::YEAR_W-1:0]           year,
	output logic [e2c_pkg::MONTH_W-1:0]          month,
	output logic [e2c_pkg::DOM_W-1:0]            day_of_month,
	output logic [e2c_pkg::WEEKDAY_W-1:0]        weekday,
	output logic [e2c_pkg::DOY_W-1:0]            day_of_year
);

	localparam int DW   = e2c_pkg::DAYS_W;
	localparam int WSW  = e2c_pkg::DAYS_W + 1;
	localparam int WPW  = WSW + e2c_pkg::WEEK_RECIP_W;
	localparam int YPW  = e2c_pkg::DAYS_W + e2c_pkg::YEAR_RECIP_W;
	localparam int YOW  = e2c_pkg::YOFF_W;
	localparam int YW   = e2c_pkg::YEAR_W;
	localparam int CPW  = e2c_pkg::YEAR_W + e2c_pkg::C100_RECIP_W;
	localparam int CW   = e2c_pkg::CENT_W;
	localparam int LW   = e2c_pkg::LCNT_W;
	localparam int STW  = e2c_pkg::YSTART_W;
	localparam int DYW  = e2c_pkg::DOY_W;
	localparam int MW   = e2c_pkg::MONTH_W;
	localparam int DMW  = e2c_pkg::DOM_W;
	localparam int WDW  = e2c_pkg::WEEKDAY_W;
	localparam int WQW  = e2c_pkg::WQ_W;
	localparam int NC   = e2c_pkg::YEAR_CANDS;

	// Leap years up to and including the year before the epoch.
	localparam int EPOCH_PREV   = EPOCH_YEAR - 1;
	localparam int LEAPS_BEFORE = EPOCH_PREV / 4 - EPOCH_PREV / 100 + EPOCH_PREV / 400;

	logic [WSW-1:0] wsum;
	logic [WPW-1:0] wprod;
	logic [YPW-1:0] yprod;
	logic [YOW-1:0] ycand;
	logic [YW-1:0]  yr [NC];
	logic [CPW-1:0] cprod [NC];
	logic [LW-1:0]  lcnt [NC];
	logic           leap [NC];
	logic [STW-1:0] ystart [NC];
	logic [STW-1:0] dext;
	logic [1:0]     sel;
	logic [MW-1:0]  mcount;
	logic [DYW-1:0] mstart;

	logic [WSW-1:0] wsum_s3;
	logic [WQW-1:0] wq_s3;
	logic [YOW-1:0] ye_s3;
	logic [DW-1:0]  days_s3, days_s4, days_s5, days_s6;
	logic [WDW-1:0] weekday_s4, weekday_s5, weekday_s6, weekday_s7, weekday_s8, weekday_s9;
	logic [YOW-1:0] yc_s4, yc_s5, yc_s6;
	logic [YW-1:0]  yr_s4 [NC];
	logic [CW-1:0]  cent_s4 [NC];
	logic [LW-1:0]  lcnt_s5 [NC];
	logic           leap_s5 [NC];
	logic           leap_s6 [NC];
	logic [STW-1:0] start_s6 [NC];
	logic [YW-1:0]  year_s7, year_s8, year_s9;
	logic [DYW-1:0] doy_s7, doy_s8, doy_s9;
	logic           leap_s7, leap_s8;
	logic [MW-1:0]  month_s8, month_s9;
	logic [DMW-1:0] dom_s9;

	// Stage 3: reciprocal products for the weekday and the year estimate.
	assign wsum  = WSW'(days) + WSW'(EPOCH_WEEKDAY);
	assign wprod = WPW'(wsum) * WPW'(e2c_pkg::WEEK_RECIP);
	assign yprod = YPW'(days) * YPW'(e2c_pkg::YEAR_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			wsum_s3 <= wsum;
			wq_s3   <= wprod[e2c_pkg::WEEK_SHIFT +: WQW];
			ye_s3   <= yprod[e2c_pkg::YEAR_SHIFT +: YOW];
			days_s3 <= days;
		end
	end

	// Stage 4: the true year lies within one of the estimate, so three
	// neighbouring candidates are examined, each with its century count.
	always_comb begin
		ycand = (ye_s3 == '0) ? '0 : ye_s3 - 1'b1;
		for (int k = 0; k < NC; k++) begin
			yr[k]    = YW'(EPOCH_YEAR) + YW'(ycand) + YW'(k);
			cprod[k] = CPW'(yr[k]) * CPW'(e2c_pkg::C100_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			weekday_s4 <= WDW'(wsum_s3 - WSW'(wq_s3) * WSW'(e2c_pkg::DAYS_PER_WEEK));
			yc_s4      <= ycand;
			days_s4    <= days_s3;
			for (int k = 0; k < NC; k++) begin
				yr_s4[k]   <= yr[k];
				cent_s4[k] <= cprod[k][e2c_pkg::C100_SHIFT +: CW];
			end
		end
	end

	// Stage 5: leap flag and running leap count of each candidate year.
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			lcnt[k] = LW'(yr_s4[k][YW-1:2]) - LW'(cent_s4[k]) + LW'(cent_s4[k][CW-1:2]);
			leap[k] = (yr_s4[k][1:0] == 2'b00)
				&& ((yr_s4[k] != YW'(cent_s4[k]) * YW'(e2c_pkg::YEARS_PER_CENTURY))
				|| (cent_s4[k][1:0] == 2'b00));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			weekday_s5 <= weekday_s4;
			yc_s5      <= yc_s4;
			days_s5    <= days_s4;
			for (int k = 0; k < NC; k++) begin
				lcnt_s5[k] <= lcnt[k];
				leap_s5[k] <= leap[k];
			end
		end
	end

	// Stage 6: first day of each candidate year, counted from the epoch.
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			ystart[k] = (STW'(yc_s5) + STW'(k)) * STW'(e2c_pkg::DAYS_PER_YEAR)
				+ STW'(lcnt_s5[k]) - STW'(leap_s5[k]) - STW'(LEAPS_BEFORE);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			weekday_s6 <= weekday_s5;
			yc_s6      <= yc_s5;
			days_s6    <= days_s5;
			for (int k = 0; k < NC; k++) begin
				start_s6[k] <= ystart[k];
				leap_s6[k]  <= leap_s5[k];
			end
		end
	end

	// Stage 7: pick the candidate whose year contains the day count.
	always_comb begin
		dext = STW'(days_s6);
		if (dext >= start_s6[2]) begin
			sel = 2'd2;
		end else if (dext >= start_s6[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			year_s7    <= YW'(EPOCH_YEAR) + YW'(yc_s6) + YW'(sel);
			doy_s7     <= DYW'(dext - start_s6[sel]);
			leap_s7    <= leap_s6[sel];
			weekday_s7 <= weekday_s6;
		end
	end

	// Stage 8: month from the count of month starts already passed.
	always_comb begin
		mcount = '0;
		for (int m = 1; m < e2c_pkg::MONTHS; m++) begin
			if (doy_s7 >= e2c_pkg::MONTH_START[m] + DYW'(leap_s7 && (m >= e2c_pkg::MARCH))) begin
				mcount = mcount + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			month_s8   <= mcount;
			doy_s8     <= doy_s7;
			leap_s8    <= leap_s7;
			year_s8    <= year_s7;
			weekday_s8 <= weekday_s7;
		end
	end

	// Stage 9: day within the month.
	assign mstart = e2c_pkg::MONTH_START[month_s8]
		+ DYW'(leap_s8 && (month_s8 >= e2c_pkg::MARCH));

	always_ff @(posedge clk) begin
		if (ctl.load[8]) begin
			dom_s9     <= DMW'(doy_s8 - mstart + 1'b1);
			month_s9   <= month_s8;
			doy_s9     <= doy_s8;
			year_s9    <= year_s8;
			weekday_s9 <= weekday_s8;
		end
	end

	assign year         = year_s9;
	assign month        = month_s9;
	assign day_of_month = dom_s9;
	assign weekday      = weekday_s9;
	assign day_of_year  = doy_s9;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the epoch seconds to calendar converter.
`timescale 1ns / 1ps

module testbench;

	localparam int SECS_W    = e2c_pkg::SECS_W;
	localparam int OFFSET_W  = e2c_pkg::OFFSET_W;
	localparam int YEAR_W    = e2c_pkg::YEAR_W;
	localparam int MONTH_W   = e2c_pkg::MONTH_W;
	localparam int DOM_W     = e2c_pkg::DOM_W;
	localparam int HOUR_W    = e2c_pkg::HOUR_W;
	localparam int MINUTE_W  = e2c_pkg::MINUTE_W;
	localparam int SECOND_W  = e2c_pkg::SECOND_W;
	localparam int WEEKDAY_W = e2c_pkg::WEEKDAY_W;
	localparam int DOY_W     = e2c_pkg::DOY_W;

	typedef struct packed {
		logic [YEAR_W-1:0]    year;
		logic [MONTH_W-1:0]   month;
		logic [DOM_W-1:0]     day_of_month;
		logic [HOUR_W-1:0]    hour;
		logic [MINUTE_W-1:0]  minute;
		logic [SECOND_W-1:0]  second;
		logic [WEEKDAY_W-1:0] weekday;
		logic [DOY_W-1:0]     day_of_year;
	} calendar_t;

	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned DAY_SECS  = 86400;
	localparam int unsigned HOUR_SECS = 3600;
	localparam int unsigned MIN_SECS  = 60;
	localparam int          MAX_PRINTED = 50;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic signed [OFFSET_W-1:0]  utc_offset = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [SECS_W-1:0]           epoch_seconds = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [YEAR_W-1:0]           year;
	logic [MONTH_W-1:0]          month;
	logic [DOM_W-1:0]            day_of_month;
	logic [HOUR_W-1:0]           hour;
	logic [MINUTE_W-1:0]         minute;
	logic [SECOND_W-1:0]         second;
	logic [WEEKDAY_W-1:0]        weekday;
	logic [DOY_W-1:0]            day_of_year;

	logic [SECS_W-1:0]           pending_secs [$];
	calendar_t                   expected_dates [$];
	logic signed [OFFSET_W-1:0]  zone_offset = '0;
	int                          tx_idle_pct = 0;
	int                          rx_idle_pct = 0;
	logic                        rx_hold = 1'b0;
	bit                          hold_go = 1'b0;
	int                          mismatches = 0;

	epoch_seconds_to_calendar dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.utc_offset   (utc_offset),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.epoch_seconds(epoch_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.weekday      (weekday),
		.day_of_year  (day_of_year)
	);

	always #5 clk = ~clk;

	function automatic bit is_leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// Expected calendar fields for one count of seconds under the given zone offset.
	function automatic calendar_t calendar_of(input logic [SECS_W-1:0] secs,
			input logic signed [OFFSET_W-1:0] ofs);
		logic [SECS_W-1:0] local_secs;
		int unsigned       days;
		int unsigned       sod;
		int unsigned       yr;
		int unsigned       ylen;
		int unsigned       mo;
		int unsigned       mlen;
		int unsigned       leap;
		calendar_t         c;
		// The sum wraps modulo 2^32, so an offset can carry the time across either end.
		local_secs = secs + {{(SECS_W - OFFSET_W){ofs[OFFSET_W-1]}}, ofs};
		days = local_secs / DAY_SECS;
		sod = local_secs % DAY_SECS;
		c.hour = HOUR_W'(sod / HOUR_SECS);
		c.minute = MINUTE_W'((sod % HOUR_SECS) / MIN_SECS);
		c.second = SECOND_W'(sod % MIN_SECS);
		c.weekday = WEEKDAY_W'((days + e2c_pkg::EPOCH_WEEKDAY_DEF) % 7);
		yr = e2c_pkg::EPOCH_YEAR_DEF;
		ylen = is_leap_year(yr) ? 366 : 365;
		while (days >= ylen) begin
			days -= ylen;
			yr++;
			ylen = is_leap_year(yr) ? 366 : 365;
		end
		c.year = YEAR_W'(yr);
		c.day_of_year = DOY_W'(days);
		leap = is_leap_year(yr) ? 1 : 0;
		mo = 0;
		while (mo < 11) begin
			mlen = MONTH_DAYS[mo] + ((mo == 1) ? leap : 0);
			if (days < mlen)
				break;
			days -= mlen;
			mo++;
		end
		c.month = MONTH_W'(mo);
		c.day_of_month = DOM_W'(days + 1);
		return c;
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("tb: %0t %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Driver: offers queued items, holding each one steady until its transfer completes.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			expected_dates.push_back(calendar_of(epoch_seconds, zone_offset));
		if (!in_valid || !in_stall) begin
			if (arst_n && pending_secs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				epoch_seconds <= pending_secs.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result transfer against the oldest expected date.
	always @(posedge clk) begin : monitor
		calendar_t want;
		if (out_valid && !out_stall) begin
			if (expected_dates.size() == 0) begin
				note_mismatch("unexpected result, year", year, 0);
			end else begin
				want = expected_dates.pop_front();
				if (year !== want.year)
					note_mismatch("year", year, want.year);
				if (month !== want.month)
					note_mismatch("month", month, want.month);
				if (day_of_month !== want.day_of_month)
					note_mismatch("day_of_month", day_of_month, want.day_of_month);
				if (hour !== want.hour)
					note_mismatch("hour", hour, want.hour);
				if (minute !== want.minute)
					note_mismatch("minute", minute, want.minute);
				if (second !== want.second)
					note_mismatch("second", second, want.second);
				if (weekday !== want.weekday)
					note_mismatch("weekday", weekday, want.weekday);
				if (day_of_year !== want.day_of_year)
					note_mismatch("day_of_year", day_of_year, want.day_of_year);
			end
		end
		out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
	end

	// Long receiver hold-off so that the pipeline fills and pushes back on the sender.
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (80) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_secs.size() != 0 || in_valid || expected_dates.size() != 0);
		repeat (e2c_pkg::STAGES + 2) @(negedge clk);
	endtask

	task automatic load_offset(input logic signed [OFFSET_W-1:0] value);
		bit took;
		@(posedge clk);
		cfg_valid <= 1'b1;
		utc_offset <= value;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		zone_offset = value;
	endtask

	// Mostly uniform times, with a share placed a few seconds either side of midnight.
	task automatic queue_random(input int count);
		logic [SECS_W-1:0] secs;
		repeat (count) begin
			if ($urandom_range(3) == 0) begin
				secs = $urandom_range(49710) * DAY_SECS;
				secs = secs + $urandom_range(4) - 2;
			end else begin
				secs = $urandom;
			end
			pending_secs.push_back(secs);
		end
	endtask

	task automatic set_idling(input int tx, input int rx);
		tx_idle_pct = tx;
		rx_idle_pct = rx;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Zero offset from reset: field extremes, leap days and the non-leap century year.
		set_idling(16, 71);
		pending_secs = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
			32'd86400, 32'd5011199, 32'd5011200, 32'd5097600, 32'd31536000, 32'd31622399,
			32'd31622400, 32'd3160857599, 32'd3160857600, 32'd3187209600, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
		queue_random(50);
		wait_drained();

		// Negative offset of fourteen hours: times near the epoch wrap to the top.
		load_offset(-17'sd50400);
		pending_secs = '{32'd0, 32'd1, 32'd50399, 32'd50400, 32'd50401};
		queue_random(50);
		wait_drained();

		// Positive offset of fourteen hours: times near the top wrap to the epoch.
		set_idling(71, 16);
		load_offset(17'sd50400);
		pending_secs = '{32'hFFFF_FFFF, 32'hFFFF_FFFF - 32'd50399, 32'hFFFF_FFFF - 32'd50400,
			32'd0};
		queue_random(50);
		wait_drained();

		// Most negative 17-bit offset, used as is without saturation.
		load_offset(17'h10000);
		pending_secs = '{32'd0, 32'd65535, 32'd65536, 32'hFFFF_FFFF};
		queue_random(50);
		wait_drained();

		set_idling(0, 0);
		load_offset(17'sd65535);
		pending_secs = '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'd0};
		hold_go = 1'b1;
		queue_random(70);
		wait_drained();

		// The sender pauses halfway until every result is back.
		load_offset(OFFSET_W'($urandom_range(17'h1FFFF)));
		queue_random(30);
		wait_drained();
		queue_random(30);
		wait_drained();

		load_offset('0);
		queue_random(40);
		wait_drained();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
